@@ src/csvq_pkg.sv @@
package csvq_pkg;

    localparam int UNIT_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [UNIT_W-1:0] unit_t;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_DELIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_DELIM = 2'd2;

    localparam unit_t QUOTE_RESET = 16'd34;
    localparam unit_t FIELD_DELIM_RESET = 16'd44;
    localparam unit_t LINE_DELIM_RESET = 16'd10;

    typedef struct packed {
        unit_t quote_char;
        unit_t field_delim_char;
        unit_t line_delim_char;
    } cfg_t;

    typedef struct packed {
        logic  inside_quotes;
        logic  quote_seen;
        logic  field_is_quoted;
        logic  at_field_start;
        logic  row_has_text;
        logic  held_valid;
        unit_t held_unit;
        logic  drop_next_quote;
    } state_t;

    typedef struct packed {
        unit_t field_unit;
        logic  unit_valid;
        logic  field_done;
        logic  row_done;
    } result_t;

    localparam state_t STATE_RESET = '{
        inside_quotes:   1'b0,
        quote_seen:      1'b0,
        field_is_quoted: 1'b0,
        at_field_start:  1'b1,
        row_has_text:    1'b0,
        held_valid:      1'b0,
        held_unit:       '0,
        drop_next_quote: 1'b0
    };

endpackage

@@ src/csvq_if.sv @@
interface csvq_text_if;
    import csvq_pkg::*;

    logic  valid;
    logic  ready;
    unit_t text_unit;
    logic  end_of_text;

    modport source (output valid, output text_unit, output end_of_text, input ready);
    modport sink (input valid, input text_unit, input end_of_text, output ready);
endinterface

interface csvq_result_if;
    import csvq_pkg::*;

    logic  valid;
    logic  ready;
    unit_t field_unit;
    logic  unit_valid;
    logic  field_done;
    logic  row_done;

    modport source (output valid, output field_unit, output unit_valid,
                    output field_done, output row_done, input ready);
    modport sink (input valid, input field_unit, input unit_valid,
                  input field_done, input row_done, output ready);
endinterface

@@ src/csvq_cfg.sv @@
module csvq_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [csvq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csvq_pkg::UNIT_W-1:0]      cfg_data,
    output csvq_pkg::cfg_t                   cfg
);
    import csvq_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.quote_char       <= QUOTE_RESET;
            cfg_reg.field_delim_char <= FIELD_DELIM_RESET;
            cfg_reg.line_delim_char  <= LINE_DELIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUOTE:       cfg_reg.quote_char       <= cfg_data;
                CFG_FIELD_DELIM: cfg_reg.field_delim_char <= cfg_data;
                CFG_LINE_DELIM:  cfg_reg.line_delim_char  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/csvq_step.sv @@
module csvq_step (
    input  csvq_pkg::cfg_t                cfg,
    input  csvq_pkg::state_t              state,
    input  logic [csvq_pkg::UNIT_W-1:0]   text_unit,
    input  logic                          end_of_text,
    output csvq_pkg::state_t              state_next,
    output csvq_pkg::result_t             result
);
    import csvq_pkg::*;

    typedef struct packed {
        state_t  st;
        result_t res;
    } step_t;

    // held unit goes out through the doubled-quote collapse
    function automatic step_t release_held(step_t x, unit_t q);
        step_t y;
        y = x;
        if (x.st.held_valid)
        begin
            if (x.st.held_unit == q)
            begin
                if (x.st.drop_next_quote)
                    y.st.drop_next_quote = 1'b0;
                else
                begin
                    y.res.field_unit = x.st.held_unit;
                    y.res.unit_valid = 1'b1;
                    y.st.drop_next_quote = 1'b1;
                end
            end
            else
            begin
                y.res.field_unit = x.st.held_unit;
                y.res.unit_valid = 1'b1;
                y.st.drop_next_quote = 1'b0;
            end
            y.st.held_valid = 1'b0;
            y.st.held_unit = '0;
        end
        return y;
    endfunction

    function automatic step_t take_content(step_t x, unit_t u, unit_t q);
        step_t y;
        y = x;
        y.st.at_field_start = 1'b0;
        if (x.st.field_is_quoted)
        begin
            y = release_held(y, q);
            y.st.held_unit = u;
            y.st.held_valid = 1'b1;
        end
        else
        begin
            y.res.field_unit = u;
            y.res.unit_valid = 1'b1;
        end
        return y;
    endfunction

    function automatic state_t clear_field(state_t s);
        state_t t;
        t = STATE_RESET;
        t.row_has_text = s.row_has_text;
        return t;
    endfunction

    step_t w;

    always_comb
    begin
        w.st = state;
        w.res = '0;
        if (end_of_text)
        begin
            if (state.row_has_text)
            begin
                if (state.field_is_quoted && state.inside_quotes)
                    w = release_held(w, cfg.quote_char);
                w.res.field_done = 1'b1;
                w.res.row_done = 1'b1;
            end
            w.st = clear_field(w.st);
            w.st.row_has_text = 1'b0;
        end
        else
        begin
            w.st.row_has_text = 1'b1;
            if (w.st.inside_quotes)
            begin
                if (w.st.quote_seen)
                begin
                    if (text_unit != cfg.quote_char)
                        w.st.inside_quotes = 1'b0;
                    w.st.quote_seen = 1'b0;
                end
                else if (text_unit == cfg.quote_char)
                    w.st.quote_seen = 1'b1;
            end
            if (w.st.inside_quotes)
                w = take_content(w, text_unit, cfg.quote_char);
            else if (text_unit == cfg.field_delim_char || text_unit == cfg.line_delim_char)
            begin
                w.res.field_done = 1'b1;
                if (text_unit != cfg.field_delim_char)
                begin
                    w.res.row_done = 1'b1;
                    w.st.row_has_text = 1'b0;
                end
                w.st = clear_field(w.st);
            end
            else if (text_unit == cfg.quote_char)
            begin
                w.st.inside_quotes = 1'b1;
                w.st.quote_seen = 1'b0;
                if (w.st.at_field_start)
                begin
                    w.st.field_is_quoted = 1'b1;
                    w.st.at_field_start = 1'b0;
                end
                else
                    w = take_content(w, text_unit, cfg.quote_char);
            end
            else
                w = take_content(w, text_unit, cfg.quote_char);
        end
    end

    assign state_next = w.st;
    assign result = w.res;

endmodule

@@ src/csv_quoted_field_tokenizer.sv @@
// Channel   Dir  Beat payload
// text      in   text_unit[15:0], end_of_text
// tokens    out  field_unit[15:0], unit_valid, field_done, row_done
// cfg_*     in   write enable, index (0 quote, 1 field delim, 2 line delim), data
//
// One beat in per cycle and one beat out per cycle while tokens.ready stays high; a result beat
// passes from the input register through the parse step into the result register.
// The parse state loop (one compare set plus the quote collapse) is combinational into state_reg.
// rst_n clears the pipeline, parse state and delimiter registers to their defaults.
// A stall on tokens backs up through the input register; text.ready drops only
// when both stages are full and tokens.ready is low.
module csv_quoted_field_tokenizer (
    input  logic                             clk,
    input  logic                             rst_n,
    csvq_text_if.sink                        text,
    csvq_result_if.source                    tokens,
    input  logic                             cfg_we,
    input  logic [csvq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [csvq_pkg::UNIT_W-1:0]      cfg_data
);
    import csvq_pkg::*;

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    unit_t   in_unit_reg;
    logic    in_eot_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic    out_take;
    logic    advance;
    logic    in_take;

    csvq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csvq_step u_step (
        .cfg         (cfg),
        .state       (state_reg),
        .text_unit   (in_unit_reg),
        .end_of_text (in_eot_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    assign out_take   = !out_valid_reg || tokens.ready;
    assign advance    = in_valid_reg && out_take;
    assign text.ready = !in_valid_reg || out_take;
    assign in_take    = text.valid && text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (out_take)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_unit_reg <= text.text_unit;
            in_eot_reg  <= text.end_of_text;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign tokens.valid      = out_valid_reg;
    assign tokens.field_unit = result_reg.field_unit;
    assign tokens.unit_valid = result_reg.unit_valid;
    assign tokens.field_done = result_reg.field_done;
    assign tokens.row_done   = result_reg.row_done;

endmodule

@@ src/csvq_checker.sv @@
module csvq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [csvq_pkg::UNIT_W-1:0]   field_unit,
    input logic                          unit_valid,
    input logic                          field_done,
    input logic                          row_done
);

    // stalled result beat must hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(field_unit)
            && $stable(unit_valid) && $stable(field_done) && $stable(row_done))
        else $error("result beat changed while stalled");

    a_row_ends_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && row_done |-> field_done)
        else $error("row end without field end");

    a_unit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !unit_valid |-> field_unit == '0)
        else $error("field_unit nonzero with no character");

endmodule

bind csv_quoted_field_tokenizer csvq_checker u_csvq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (tokens.valid),
    .out_ready  (tokens.ready),
    .field_unit (tokens.field_unit),
    .unit_valid (tokens.unit_valid),
    .field_done (tokens.field_done),
    .row_done   (tokens.row_done)
);

@@ verif/csv_quoted_field_tokenizer_tb.sv @@
`timescale 1ns / 100ps

module csv_quoted_field_tokenizer_tb;
    import csvq_pkg::*;

    localparam int RANDOM_UNITS = 1800;
    localparam int PHASES = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_PRINTED = 40;

    localparam unit_t CH_A = 16'h0061;
    localparam unit_t CH_B = 16'h0062;
    localparam unit_t CH_Y = 16'h0079;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    unit_t cfg_data;

    csvq_text_if text_bus ();
    csvq_result_if token_bus ();

    csv_quoted_field_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text      (text_bus),
        .tokens    (token_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // tokenizer copy: parse state and delimiter settings
    state_t parse_st;
    cfg_t delims;
    result_t expected_tokens[$];

    int errors = 0;
    int cycles = 0;
    int units_sent = 0;
    int sink_wait = 0;
    bit src_calm = 1'b0;
    bit sink_calm = 1'b0;

    task automatic report(input string what);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // hand the held unit out; a quote right after an emitted quote is dropped
    function automatic void pass_held(inout result_t r);
        if (!parse_st.held_valid)
            return;
        if (parse_st.held_unit == delims.quote_char)
        begin
            if (parse_st.drop_next_quote)
                parse_st.drop_next_quote = 1'b0;
            else
            begin
                r.field_unit = parse_st.held_unit;
                r.unit_valid = 1'b1;
                parse_st.drop_next_quote = 1'b1;
            end
        end
        else
        begin
            r.field_unit = parse_st.held_unit;
            r.unit_valid = 1'b1;
            parse_st.drop_next_quote = 1'b0;
        end
        parse_st.held_valid = 1'b0;
        parse_st.held_unit = '0;
    endfunction

    function automatic void add_content(input unit_t u, inout result_t r);
        parse_st.at_field_start = 1'b0;
        if (parse_st.field_is_quoted)
        begin
            pass_held(r);
            parse_st.held_unit = u;
            parse_st.held_valid = 1'b1;
        end
        else
        begin
            r.field_unit = u;
            r.unit_valid = 1'b1;
        end
    endfunction

    function automatic void clear_field();
        logic keep;
        keep = parse_st.row_has_text;
        parse_st = STATE_RESET;
        parse_st.row_has_text = keep;
    endfunction

    function automatic result_t parse_unit(input unit_t u, input logic eot);
        result_t r;
        r = '0;
        if (eot)
        begin
            if (parse_st.row_has_text)
            begin
                if (parse_st.field_is_quoted && parse_st.inside_quotes)
                    pass_held(r);
                r.field_done = 1'b1;
                r.row_done = 1'b1;
            end
            clear_field();
            parse_st.row_has_text = 1'b0;
        end
        else
        begin
            parse_st.row_has_text = 1'b1;
            if (parse_st.inside_quotes)
            begin
                if (parse_st.quote_seen)
                begin
                    if (u != delims.quote_char)
                        parse_st.inside_quotes = 1'b0;
                    parse_st.quote_seen = 1'b0;
                end
                else if (u == delims.quote_char)
                    parse_st.quote_seen = 1'b1;
            end
            if (parse_st.inside_quotes)
                add_content(u, r);
            else if (u == delims.field_delim_char || u == delims.line_delim_char)
            begin
                r.field_done = 1'b1;
                if (u != delims.field_delim_char)
                begin
                    r.row_done = 1'b1;
                    parse_st.row_has_text = 1'b0;
                end
                clear_field();
            end
            else if (u == delims.quote_char)
            begin
                parse_st.inside_quotes = 1'b1;
                parse_st.quote_seen = 1'b0;
                if (parse_st.at_field_start)
                begin
                    parse_st.field_is_quoted = 1'b1;
                    parse_st.at_field_start = 1'b0;
                end
                else
                    add_content(u, r);
            end
            else
                add_content(u, r);
        end
        return r;
    endfunction

    task automatic send_unit(input unit_t u, input logic eot);
        int gap;
        if ($urandom_range(0, 39) == 0)
            src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 17);
        @(negedge clk);
        if (gap > 0)
        begin
            text_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_bus.valid = 1'b1;
        text_bus.text_unit = u;
        text_bus.end_of_text = eot;
        @(posedge clk);
        while (!text_bus.ready)
            @(posedge clk);
        expected_tokens.push_back(parse_unit(u, eot));
        units_sent++;
    endtask

    task automatic send_units(input unit_t seq[$]);
        foreach (seq[i])
            send_unit(seq[i], 1'b0);
    endtask

    task automatic send_end();
        send_unit(unit_t'($urandom), 1'b1);
    endtask

    // wait for every expected beat, then let the pipeline go quiet
    task automatic settle();
        @(negedge clk);
        text_bus.valid = 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input unit_t val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_QUOTE: delims.quote_char = val;
            CFG_FIELD_DELIM: delims.field_delim_char = val;
            CFG_LINE_DELIM: delims.line_delim_char = val;
            default: ;
        endcase
    endtask

    task automatic set_delims(input unit_t q, input unit_t f, input unit_t l);
        settle();
        write_reg(CFG_QUOTE, q);
        write_reg(CFG_FIELD_DELIM, f);
        write_reg(CFG_LINE_DELIM, l);
    endtask

    function automatic unit_t plain_unit();
        unit_t u;
        do
            u = unit_t'($urandom);
        while (u == delims.quote_char || u == delims.field_delim_char ||
               u == delims.line_delim_char);
        return u;
    endfunction

    function automatic unit_t noise_unit();
        case ($urandom_range(0, 5))
            0: return delims.quote_char;
            1: return delims.field_delim_char;
            2: return delims.line_delim_char;
            default: return unit_t'($urandom);
        endcase
    endfunction

    // one well-formed row: plain, empty and quoted fields with random content
    task automatic send_row();
        int nf;
        int len;
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++)
        begin
            case ($urandom_range(0, 3))
                0: ;
                3:
                begin
                    send_unit(delims.quote_char, 1'b0);
                    len = $urandom_range(0, 5);
                    repeat (len)
                    begin
                        case ($urandom_range(0, 5))
                            0:
                            begin
                                send_unit(delims.quote_char, 1'b0);
                                send_unit(delims.quote_char, 1'b0);
                            end
                            1: send_unit(delims.field_delim_char, 1'b0);
                            2: send_unit(delims.line_delim_char, 1'b0);
                            default: send_unit(plain_unit(), 1'b0);
                        endcase
                    end
                    send_unit(delims.quote_char, 1'b0);
                end
                default:
                    repeat ($urandom_range(1, 5)) send_unit(plain_unit(), 1'b0);
            endcase
            if (f < nf - 1)
                send_unit(delims.field_delim_char, 1'b0);
        end
        if ($urandom_range(0, 7) == 0)
            send_end();
        else
            send_unit(delims.line_delim_char, 1'b0);
    endtask

    task automatic test_default_delims();
        send_end();    // nothing since reset: no row
        // doubled quote collapse, newline right after the closing quote
        send_units('{QUOTE_RESET, CH_A, QUOTE_RESET, QUOTE_RESET, CH_B, QUOTE_RESET,
                     LINE_DELIM_RESET});
        send_units('{LINE_DELIM_RESET});
        // newline inside the span, end of text releases the held unit
        send_units('{QUOTE_RESET, 16'h0000, LINE_DELIM_RESET});
        send_end();
        // span already closed at end of text: held unit is dropped
        send_units('{QUOTE_RESET, CH_Y, QUOTE_RESET, 16'hFFFF});
        send_end();
    endtask

    task automatic test_equal_delims();
        // all alike: field delimiter wins
        set_delims(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_unit(16'hFFFF, 1'b0);
        send_end();
        // quote equal to line delimiter: line delimiter wins
        set_delims(16'h0000, 16'h1234, 16'h0000);
        send_units('{16'h0000, 16'h0000});
    endtask

    task automatic test_quote_swap();
        set_delims(QUOTE_RESET, FIELD_DELIM_RESET, LINE_DELIM_RESET);
        send_units('{QUOTE_RESET, CH_A, QUOTE_RESET});
        // held quote is judged against the new quote code
        settle();
        write_reg(CFG_QUOTE, CH_A);
        send_units('{QUOTE_RESET, QUOTE_RESET, CH_A});
        send_end();
    endtask

    task automatic test_random_text();
        int target;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_delims(QUOTE_RESET, FIELD_DELIM_RESET, LINE_DELIM_RESET);
                1: set_delims(16'h0000, 16'hFFFF, 16'h0001);
                2: set_delims(16'hFFFF, 16'h0000, 16'hFFFF);
                3:
                begin
                    cfg_data = unit_t'($urandom);
                    set_delims(unit_t'($urandom), cfg_data, cfg_data);
                end
                default: set_delims(unit_t'($urandom), unit_t'($urandom),
                                    unit_t'($urandom));
            endcase
            target = units_sent + RANDOM_UNITS / PHASES;
            while (units_sent < target)
            begin
                case ($urandom_range(0, 9))
                    7, 8:
                        repeat ($urandom_range(1, 8)) send_unit(noise_unit(), 1'b0);
                    9: send_end();
                    default: send_row();
                endcase
            end
        end
    endtask

    always @(posedge clk)
    begin : check_tokens
        result_t want;
        if (rst_n && token_bus.valid && token_bus.ready)
        begin
            if (expected_tokens.size() == 0)
                report("token beat with nothing expected");
            else
            begin
                want = expected_tokens.pop_front();
                if (token_bus.field_unit !== want.field_unit)
                    report($sformatf("field_unit %h, expected %h",
                                     token_bus.field_unit, want.field_unit));
                if (token_bus.unit_valid !== want.unit_valid)
                    report($sformatf("unit_valid %b, expected %b",
                                     token_bus.unit_valid, want.unit_valid));
                if (token_bus.field_done !== want.field_done)
                    report($sformatf("field_done %b, expected %b",
                                     token_bus.field_done, want.field_done));
                if (token_bus.row_done !== want.row_done)
                    report($sformatf("row_done %b, expected %b",
                                     token_bus.row_done, want.row_done));
            end
            if ($urandom_range(0, 39) == 0)
                sink_calm = !sink_calm;
            sink_wait = sink_calm ? 0 : $urandom_range(0, 17);
        end
    end

    always @(negedge clk)
    begin
        if (sink_wait > 0)
        begin
            token_bus.ready = 1'b0;
            sink_wait--;
        end
        else
            token_bus.ready = 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_QUOTE;
        cfg_data = '0;
        text_bus.valid = 1'b0;
        text_bus.text_unit = '0;
        text_bus.end_of_text = 1'b0;
        token_bus.ready = 1'b0;
        parse_st = STATE_RESET;
        delims = '{QUOTE_RESET, FIELD_DELIM_RESET, LINE_DELIM_RESET};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_default_delims();
        test_equal_delims();
        test_quote_swap();
        test_random_text();

        settle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
src/csvq_pkg.sv
src/csvq_if.sv
src/csvq_cfg.sv
src/csvq_step.sv
src/csv_quoted_field_tokenizer.sv
src/csvq_checker.sv
verif/csv_quoted_field_tokenizer_tb.sv
